// File: rtl/core/rpsg_pkg.sv
// rpsg_pkg: shared types and constants for the rounded panel span generator
// holds the register map, the per-stage payload structs and saturation limits
// no dependencies
package rpsg_pkg;

  // configuration register map
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_PANEL_LEFT      = 3'd0,
    REG_PANEL_TOP       = 3'd1,
    REG_PANEL_WIDTH     = 3'd2,
    REG_PANEL_HEIGHT    = 3'd3,
    REG_CIRCLE_CENTER_X = 3'd4,
    REG_CIRCLE_CENTER_Y = 3'd5,
    REG_CIRCLE_RADIUS   = 3'd6,
    REG_CORNER_RADIUS   = 3'd7
  } reg_idx_t;

  // reset values
  localparam logic [12:0] RST_PANEL_LEFT      = 13'd0;
  localparam logic [12:0] RST_PANEL_TOP       = 13'd0;
  localparam logic [9:0]  RST_PANEL_WIDTH     = 10'd210;
  localparam logic [9:0]  RST_PANEL_HEIGHT    = 10'd118;
  localparam logic [12:0] RST_CIRCLE_CENTER_X = 13'd0;
  localparam logic [12:0] RST_CIRCLE_CENTER_Y = 13'd0;
  localparam logic [9:0]  RST_CIRCLE_RADIUS   = 10'd72;
  localparam logic [5:0]  RST_CORNER_RADIUS   = 6'd14;

  // rows at or beyond this index are always empty
  localparam int unsigned MAX_ROWS  = 1024;
  localparam int unsigned ROW_CMP_W = 14;

  // square root chain: one result bit per cell
  localparam int unsigned ROOT_W     = 10;
  localparam int unsigned RAD_W      = 2 * ROOT_W;
  localparam int unsigned REM_W      = ROOT_W + 1;
  localparam int unsigned ROOT_STEPS = ROOT_W;

  // output saturation
  localparam logic signed [13:0] START_X_SAT = 14'sd4095;
  localparam logic signed [14:0] LENGTH_SAT  = 15'sd1023;

  typedef struct packed {
    logic [12:0] panel_left;
    logic [12:0] panel_top;
    logic [9:0]  panel_width;
    logic [9:0]  panel_height;
    logic [12:0] circle_center_x;
    logic [12:0] circle_center_y;
    logic [9:0]  circle_radius;
    logic [5:0]  corner_radius;
  } cfg_t;

  // after the first prep stage
  typedef struct packed {
    logic [13:0] y;
    logic [14:0] dy;
    logic [5:0]  d;
    logic        cut;
    logic        corner_row;
    logic        row_ok;
  } p1_t;

  // one root lane: remaining radicand bits, partial remainder, partial root
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] q;
  } lane_t;

  typedef struct packed {
    logic [13:0] y;
    logic        row_ok;
    logic        in_circle;
    logic        corner_row;
  } side_t;

  typedef struct packed {
    lane_t circ;
    lane_t corner;
    side_t side;
  } cell_t;

  // after the first finish stage
  typedef struct packed {
    logic [13:0] y;
    logic [13:0] xl;
    logic [13:0] xr_base;
    logic [13:0] edge_x;
    logic        in_circle;
    logic        row_ok;
  } f1_t;

endpackage

// File: rtl/core/rpsg_prep.sv
// rpsg_prep: two pipeline stages that turn a row index into the two radicands
// stage one forms screen y, circle offset and corner distance, stage two squares
// depends on rpsg_pkg
module rpsg_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  rpsg_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          in_row_index,
  output logic                out_valid,
  input  logic                out_ready,
  output rpsg_pkg::cell_t     out_data
);
  import rpsg_pkg::*;

  logic        p1_vld_r;
  logic        p1_ready;
  p1_t         p1_r;
  p1_t         p1_nxt;
  logic        p2_vld_r;
  cell_t       p2_r;
  cell_t       p2_nxt;

  logic [10:0] row_plus_lr;
  logic [10:0] bot_sum;
  logic [10:0] d_bot;
  logic        top_row;
  logic        bot_row;
  logic        bot_cut;
  logic [5:0]  d_top;

  logic [11:0] lr_sq;
  logic [11:0] d_sq;
  logic signed [10:0] dy_s;
  logic signed [21:0] dy_sq;
  logic [19:0] br_sq;
  logic signed [14:0] br_s;

  // corner row classification
  always_comb begin
    row_plus_lr = {1'b0, in_row_index} + {5'd0, cfg.corner_radius};
    top_row     = in_row_index < {4'd0, cfg.corner_radius};
    bot_row     = row_plus_lr >= {1'b0, cfg.panel_height};
    bot_sum     = row_plus_lr + 11'd1;
    d_bot       = bot_sum - {1'b0, cfg.panel_height};
    bot_cut     = d_bot < {5'd0, cfg.corner_radius};
    d_top       = cfg.corner_radius - in_row_index[5:0];
  end

  // stage one payload
  always_comb begin
    p1_nxt.y  = {cfg.panel_top[12], cfg.panel_top} + {4'd0, in_row_index};
    p1_nxt.dy = {{2{cfg.panel_top[12]}}, cfg.panel_top} + {5'd0, in_row_index}
                - {{2{cfg.circle_center_y[12]}}, cfg.circle_center_y};
    p1_nxt.d          = top_row ? d_top : d_bot[5:0];
    p1_nxt.cut        = top_row || (bot_row && bot_cut);
    p1_nxt.corner_row = top_row || bot_row;
    p1_nxt.row_ok     = (in_row_index < cfg.panel_height) &&
                        (ROW_CMP_W'(in_row_index) < ROW_CMP_W'(MAX_ROWS));
  end

  // stage two: squares and radicands
  always_comb begin
    lr_sq = {6'd0, cfg.corner_radius} * {6'd0, cfg.corner_radius};
    d_sq  = {6'd0, p1_r.d} * {6'd0, p1_r.d};
    dy_s  = $signed(p1_r.dy[10:0]);
    dy_sq = dy_s * dy_s;
    br_sq = {10'd0, cfg.circle_radius} * {10'd0, cfg.circle_radius};
    br_s  = $signed({5'd0, cfg.circle_radius});

    p2_nxt.side.y          = p1_r.y;
    p2_nxt.side.row_ok     = p1_r.row_ok;
    p2_nxt.side.corner_row = p1_r.corner_row;
    p2_nxt.side.in_circle  = ($signed(p1_r.dy) < br_s) && ($signed(p1_r.dy) > -br_s);

    p2_nxt.circ.rad = p2_nxt.side.in_circle ? (br_sq - dy_sq[19:0]) : '0;
    p2_nxt.circ.rem = '0;
    p2_nxt.circ.q   = '0;

    p2_nxt.corner.rad = p1_r.cut ? {8'd0, lr_sq - d_sq} : '0;
    p2_nxt.corner.rem = '0;
    p2_nxt.corner.q   = '0;
  end

  // handshake: a stage takes data when it is empty or its content moves on
  assign p1_ready  = !p2_vld_r || out_ready;
  assign in_ready  = !p1_vld_r || p1_ready;
  assign out_valid = p2_vld_r;
  assign out_data  = p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        p1_vld_r <= in_valid;
      end
      if (p1_ready) begin
        p2_vld_r <= p1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p1_r <= p1_nxt;
    end
    if (p1_vld_r && p1_ready) begin
      p2_r <= p2_nxt;
    end
  end

endmodule

// File: rtl/core/rpsg_cell.sv
// rpsg_cell: one cell of the square root chain, one root bit per lane per cell
// runs the circle lane and the corner lane side by side and carries row data along
// depends on rpsg_pkg
module rpsg_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rpsg_pkg::cell_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rpsg_pkg::cell_t out_data
);
  import rpsg_pkg::*;

  logic  vld_r;
  cell_t data_r;
  cell_t data_nxt;

  // one restoring root step: bring down two radicand bits, try 4q+1
  function automatic lane_t root_step(input lane_t l);
    logic [REM_W+1:0] r_ext;
    logic [REM_W:0]   trial;
    logic             ge;
    lane_t            o;
    r_ext = {l.rem, l.rad[RAD_W-1 -: 2]};
    trial = {l.q, 2'b01};
    ge    = r_ext >= {1'b0, trial};
    o.rem = ge ? REM_W'(r_ext - {1'b0, trial}) : REM_W'(r_ext);
    o.q   = {l.q[ROOT_W-2:0], ge};
    o.rad = {l.rad[RAD_W-3:0], 2'b00};
    return o;
  endfunction

  always_comb begin
    data_nxt        = in_data;
    data_nxt.circ   = root_step(in_data.circ);
    data_nxt.corner = root_step(in_data.corner);
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/core/rpsg_finish.sv
// rpsg_finish: two stages that turn the roots into the span, the second is the output register
// forms left edge, right edge and length, then clips and saturates
// depends on rpsg_pkg
module rpsg_finish (
  input  logic            clk,
  input  logic            rst_n,
  input  rpsg_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  rpsg_pkg::cell_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [12:0]     out_span_start_x,
  output logic [13:0]     out_span_row_y,
  output logic [9:0]      out_span_length,
  output logic            out_span_present
);
  import rpsg_pkg::*;

  logic        f1_vld_r;
  logic        f1_ready;
  f1_t         f1_r;
  f1_t         f1_nxt;
  logic        f2_vld_r;

  logic [12:0] start_x_r;
  logic [12:0] start_x_nxt;
  logic [13:0] row_y_r;
  logic [9:0]  length_r;
  logic [9:0]  length_nxt;
  logic        present_r;
  logic        present_nxt;

  logic [5:0]  corner_off;
  logic [13:0] xr;
  logic [14:0] lw;

  // corner rows pull the left edge in by radius minus root
  function automatic logic [5:0] f1_nxt_corner_off(input cell_t c);
    logic [5:0] off;
    off = c.side.corner_row ? (cfg.corner_radius - c.corner.q[5:0]) : 6'd0;
    return off;
  endfunction

  // edges from the roots
  always_comb begin
    corner_off       = f1_nxt_corner_off(in_data);
    f1_nxt.y         = in_data.side.y;
    f1_nxt.in_circle = in_data.side.in_circle;
    f1_nxt.row_ok    = in_data.side.row_ok;
    f1_nxt.xl        = {cfg.panel_left[12], cfg.panel_left} + {8'd0, corner_off};
    f1_nxt.xr_base   = {cfg.panel_left[12], cfg.panel_left} + {4'd0, cfg.panel_width};
    f1_nxt.edge_x    = {cfg.circle_center_x[12], cfg.circle_center_x}
                       - {4'd0, in_data.circ.q};
  end

  // length, emptiness and saturation
  always_comb begin
    xr = (f1_r.in_circle && ($signed(f1_r.edge_x) < $signed(f1_r.xr_base))) ?
         f1_r.edge_x : f1_r.xr_base;
    lw = {xr[13], xr} - {f1_r.xl[13], f1_r.xl};
    present_nxt = f1_r.row_ok && !lw[14] && (lw != '0);
    if (!present_nxt) begin
      start_x_nxt = '0;
      length_nxt  = '0;
    end else begin
      start_x_nxt = ($signed(f1_r.xl) > START_X_SAT) ? START_X_SAT[12:0] : f1_r.xl[12:0];
      length_nxt  = ($signed(lw) > LENGTH_SAT) ? LENGTH_SAT[9:0] : lw[9:0];
    end
  end

  assign f1_ready  = !f2_vld_r || out_ready;
  assign in_ready  = !f1_vld_r || f1_ready;
  assign out_valid = f2_vld_r;

  assign out_span_start_x = start_x_r;
  assign out_span_row_y   = row_y_r;
  assign out_span_length  = length_r;
  assign out_span_present = present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        f1_vld_r <= in_valid;
      end
      if (f1_ready) begin
        f2_vld_r <= f1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f1_r <= f1_nxt;
    end
    if (f1_vld_r && f1_ready) begin
      start_x_r <= start_x_nxt;
      row_y_r   <= f1_r.y;
      length_r  <= length_nxt;
      present_r <= present_nxt;
    end
  end

endmodule

// File: rtl/core/rounded_panel_span_generator.sv
// rounded_panel_span_generator: top level, register file and pipeline assembly
// instantiates rpsg_prep, a chain of rpsg_cell and rpsg_finish; depends on rpsg_pkg
//
// Takes one panel row index per transaction and returns that row's fill span
// one result per row, in order. Sustained rate is one row per clock when out_ready
// holds high: the path is a 14-stage pipeline (two prep stages that form the
// radicands, a chain of ten square root cells that each resolve one root bit for
// both the circle cut and the left corner, and two finish stages, the last being
// the output register). Each stage holds its item while the next one is full, so
// gaps close up under back pressure. Registers sit at byte addresses 4*i on the
// APB port and are to be written by the user only while no rows are in flight;
// the block itself does not enforce this.
module rounded_panel_span_generator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpsg_pkg::ADDR_W-1:0]  paddr,
  input  logic [rpsg_pkg::DATA_W-1:0]  pwdata,
  output logic [rpsg_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [9:0]                   in_row_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [12:0]                  out_span_start_x,
  output logic [13:0]                  out_span_row_y,
  output logic [9:0]                   out_span_length,
  output logic                         out_span_present
);
  import rpsg_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;

  logic  cell_vld  [ROOT_STEPS+1];
  logic  cell_rdy  [ROOT_STEPS+1];
  cell_t cell_data [ROOT_STEPS+1];

  // register access
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_left      <= RST_PANEL_LEFT;
      cfg_r.panel_top       <= RST_PANEL_TOP;
      cfg_r.panel_width     <= RST_PANEL_WIDTH;
      cfg_r.panel_height    <= RST_PANEL_HEIGHT;
      cfg_r.circle_center_x <= RST_CIRCLE_CENTER_X;
      cfg_r.circle_center_y <= RST_CIRCLE_CENTER_Y;
      cfg_r.circle_radius   <= RST_CIRCLE_RADIUS;
      cfg_r.corner_radius   <= RST_CORNER_RADIUS;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_PANEL_LEFT:      cfg_r.panel_left      <= pwdata[12:0];
        REG_PANEL_TOP:       cfg_r.panel_top       <= pwdata[12:0];
        REG_PANEL_WIDTH:     cfg_r.panel_width     <= pwdata[9:0];
        REG_PANEL_HEIGHT:    cfg_r.panel_height    <= pwdata[9:0];
        REG_CIRCLE_CENTER_X: cfg_r.circle_center_x <= pwdata[12:0];
        REG_CIRCLE_CENTER_Y: cfg_r.circle_center_y <= pwdata[12:0];
        REG_CIRCLE_RADIUS:   cfg_r.circle_radius   <= pwdata[9:0];
        REG_CORNER_RADIUS:   cfg_r.corner_radius   <= pwdata[5:0];
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_PANEL_LEFT:      prdata = DATA_W'(cfg_r.panel_left);
      REG_PANEL_TOP:       prdata = DATA_W'(cfg_r.panel_top);
      REG_PANEL_WIDTH:     prdata = DATA_W'(cfg_r.panel_width);
      REG_PANEL_HEIGHT:    prdata = DATA_W'(cfg_r.panel_height);
      REG_CIRCLE_CENTER_X: prdata = DATA_W'(cfg_r.circle_center_x);
      REG_CIRCLE_CENTER_Y: prdata = DATA_W'(cfg_r.circle_center_y);
      REG_CIRCLE_RADIUS:   prdata = DATA_W'(cfg_r.circle_radius);
      REG_CORNER_RADIUS:   prdata = DATA_W'(cfg_r.corner_radius);
    endcase
  end

  // radicand stages
  rpsg_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_row_index (in_row_index),
    .out_valid    (cell_vld[0]),
    .out_ready    (cell_rdy[0]),
    .out_data     (cell_data[0])
  );

  // square root chain
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_cell
    rpsg_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cell_vld[k]),
      .in_ready  (cell_rdy[k]),
      .in_data   (cell_data[k]),
      .out_valid (cell_vld[k+1]),
      .out_ready (cell_rdy[k+1]),
      .out_data  (cell_data[k+1])
    );
  end

  // span assembly and output register
  rpsg_finish u_finish (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (cell_vld[ROOT_STEPS]),
    .in_ready         (cell_rdy[ROOT_STEPS]),
    .in_data          (cell_data[ROOT_STEPS]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_start_x (out_span_start_x),
    .out_span_row_y   (out_span_row_y),
    .out_span_length  (out_span_length),
    .out_span_present (out_span_present)
  );

endmodule

// File: rtl/core/rpsg_checker.sv
// rpsg_checker: port-level assertions for the span generator
// bound to rounded_panel_span_generator; depends on nothing else
module rpsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] out_span_start_x,
  input logic [13:0] out_span_row_y,
  input logic [9:0]  out_span_length,
  input logic        out_span_present
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_span_start_x) &&
    $stable(out_span_row_y) && $stable(out_span_length) && $stable(out_span_present))
    else $error("result changed while stalled");

  // present flag agrees with length
  a_present_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_span_present == (out_span_length != 10'd0)))
    else $error("present flag and length disagree");

  // empty rows report start zero
  a_empty_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_span_present |-> out_span_start_x == 13'd0)
    else $error("empty row with nonzero start");

  // reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rounded_panel_span_generator rpsg_checker u_rpsg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_span_start_x (out_span_start_x),
  .out_span_row_y   (out_span_row_y),
  .out_span_length  (out_span_length),
  .out_span_present (out_span_present)
);

// File: sim/tb.sv
// tb: self-checking bench for rounded_panel_span_generator
// drives rows and apb register writes, predicts each span or takes it from the directed table, and compares in order
// depends on rpsg_pkg and the rounded_panel_span_generator rtl
`timescale 1ns / 100ps

module tb;
  import rpsg_pkg::*;

  localparam int LATENCY        = 14;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 8;
  localparam int ROWS_PER_PHASE = 50;
  localparam int PLAN_LEN       = 44;

  typedef struct packed {
    logic [12:0] start_x;
    logic [13:0] row_y;
    logic [9:0]  length;
    logic        present;
  } span_t;

  typedef struct {
    bit          is_write;
    reg_idx_t    idx;
    logic [31:0] wdata;
    logic [9:0]  row;
    bit          lit;
    span_t       want;
  } step_t;

  localparam span_t NO_SPAN = '0;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [9:0]        in_row_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [12:0]       out_span_start_x;
  logic [13:0]       out_span_row_y;
  logic [9:0]        out_span_length;
  logic              out_span_present;

  cfg_t  cfg_shadow;
  span_t pending_spans[$];
  step_t plan [PLAN_LEN];
  int    mismatches = 0;
  int    spans_checked = 0;
  int    rows_sent = 0;
  int    settings_used = 1;
  int    hold_left = 0;
  int    stall_left = 0;
  int    stuck_cycles = 0;
  bit    hold_req = 1'b0;
  bit    hold_done = 1'b0;
  bit    no_idle = 1'b0;

  rounded_panel_span_generator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_row_index     (in_row_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_start_x (out_span_start_x),
    .out_span_row_y   (out_span_row_y),
    .out_span_length  (out_span_length),
    .out_span_present (out_span_present)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact floor square root by bisection
  function automatic longint int_sqrt(input longint n);
    longint lo, hi, mid;
    if (n <= 0) return 0;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // span of one row under the current register settings
  function automatic span_t predict_span(input logic [9:0] row_in);
    longint row, px, py, pw, ph, cx, cy, cr, lr;
    longint y, left, right, dy, d, cut_x, len;
    bit     ok;
    span_t  s;
    row = row_in;
    px  = $signed(cfg_shadow.panel_left);
    py  = $signed(cfg_shadow.panel_top);
    pw  = cfg_shadow.panel_width;
    ph  = cfg_shadow.panel_height;
    cx  = $signed(cfg_shadow.circle_center_x);
    cy  = $signed(cfg_shadow.circle_center_y);
    cr  = cfg_shadow.circle_radius;
    lr  = cfg_shadow.corner_radius;
    y   = py + row;
    left = px;
    // rounded left corners, negative radicand clamps to zero
    if (row < lr) begin
      d = lr - row;
      left = px + lr - int_sqrt(lr * lr - d * d);
    end else if (row >= ph - lr) begin
      d = lr - (ph - 1 - row);
      left = px + lr - int_sqrt(lr * lr - d * d);
    end
    // concave cut on the right edge
    right = px + pw;
    dy = y - cy;
    if ((dy < 0 ? -dy : dy) < cr) begin
      cut_x = cx - int_sqrt(cr * cr - dy * dy);
      if (cut_x < right) right = cut_x;
    end
    len = right - left;
    ok = (row < ph) && (row < longint'(MAX_ROWS)) && (len > 0);
    if (!ok) begin
      len  = 0;
      left = 0;
    end
    if (left > 4095) left = 4095;
    if (len > 1023) len = 1023;
    s.start_x = left[12:0];
    s.row_y   = y[13:0];
    s.length  = len[9:0];
    s.present = ok;
    return s;
  endfunction

  function automatic int clamp13(input int v);
    if (v < -4096) return -4096;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0: return -4096;
      1: return 4095;
      2, 3: return int'($urandom_range(0, 8191)) - 4096;
      default: return int'($urandom_range(0, 1600)) - 800;
    endcase
  endfunction

  // rows lean on the corners and the panel bottom, with some anywhere
  function automatic logic [9:0] pick_row();
    int hi, lo;
    hi = int'(cfg_shadow.panel_height) + 2;
    if (hi > 1023) hi = 1023;
    lo = int'(cfg_shadow.panel_height) - int'(cfg_shadow.corner_radius) - 1;
    if (lo < 0) lo = 0;
    case ($urandom_range(0, 7))
      0: return 10'($urandom_range(0, 1023));
      1: return 10'($urandom_range(0, cfg_shadow.corner_radius));
      2: return 10'($urandom_range(lo, hi));
      default: return 10'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // compare one result transaction with the oldest pending span
  task automatic check_span();
    span_t want;
    if (pending_spans.size() == 0) begin
      report_mismatch($sformatf("span for row y %0d with no row pending",
                                $signed(out_span_row_y)));
      return;
    end
    want = pending_spans.pop_front();
    spans_checked++;
    if (out_span_start_x !== want.start_x)
      report_mismatch($sformatf("row y %0d start_x got %0d want %0d", $signed(want.row_y),
                                $signed(out_span_start_x), $signed(want.start_x)));
    if (out_span_row_y !== want.row_y)
      report_mismatch($sformatf("row_y got %0d want %0d", $signed(out_span_row_y),
                                $signed(want.row_y)));
    if (out_span_length !== want.length)
      report_mismatch($sformatf("row y %0d length got %0d want %0d", $signed(want.row_y),
                                out_span_length, want.length));
    if (out_span_present !== want.present)
      report_mismatch($sformatf("row y %0d present got %0b want %0b", $signed(want.row_y),
                                out_span_present, want.present));
  endtask

  // apb write: setup cycle, access cycle, then psel drops and the bus idles before the task returns
  task automatic write_reg(input reg_idx_t r, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_PANEL_LEFT:      cfg_shadow.panel_left      = value[12:0];
      REG_PANEL_TOP:       cfg_shadow.panel_top       = value[12:0];
      REG_PANEL_WIDTH:     cfg_shadow.panel_width     = value[9:0];
      REG_PANEL_HEIGHT:    cfg_shadow.panel_height    = value[9:0];
      REG_CIRCLE_CENTER_X: cfg_shadow.circle_center_x = value[12:0];
      REG_CIRCLE_CENTER_Y: cfg_shadow.circle_center_y = value[12:0];
      REG_CIRCLE_RADIUS:   cfg_shadow.circle_radius   = value[9:0];
      REG_CORNER_RADIUS:   cfg_shadow.corner_radius   = value[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one row, record its span on acceptance, then maybe idle
  task automatic send_row(input logic [9:0] row, input bit use_want, input span_t want);
    in_valid     <= 1'b1;
    in_row_index <= row;
    do @(posedge clk); while (!in_ready);
    pending_spans.push_back(use_want ? want : predict_span(row));
    rows_sent++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // stop offering rows and wait until every span has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  // result side: check, then long hold, stall bursts or ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_span();
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d spans pending",
               stuck_cycles, pending_spans.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // directed rows: literal spans where they follow directly from the settings
  initial begin
    plan = '{
      // reset settings: circle at the origin empties the top rows
      '{0, REG_PANEL_LEFT, 0, 10'd0,    1, '{13'd0,  14'd0,    10'd0,   1'b0}},
      '{0, REG_PANEL_LEFT, 0, 10'd72,   1, '{13'd0,  14'd72,   10'd210, 1'b1}},
      '{0, REG_PANEL_LEFT, 0, 10'd117,  1, '{13'd14, 14'd117,  10'd196, 1'b1}},
      '{0, REG_PANEL_LEFT, 0, 10'd118,  1, '{13'd0,  14'd118,  10'd0,   1'b0}},
      '{0, REG_PANEL_LEFT, 0, 10'd1023, 1, '{13'd0,  14'd1023, 10'd0,   1'b0}},
      // circle far above, corners alone shape the left edge
      '{1, REG_CIRCLE_CENTER_Y, 32'h1000, 10'd0, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd3,   0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd110, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd60,  0, NO_SPAN},
      // circle cutting into the right edge mid-panel
      '{1, REG_CIRCLE_CENTER_X, 32'd150, 10'd0, 0, NO_SPAN},
      '{1, REG_CIRCLE_CENTER_Y, 32'd40,  10'd0, 0, NO_SPAN},
      '{1, REG_CIRCLE_RADIUS,   32'd30,  10'd0, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd40, 1, '{13'd0, 14'd40, 10'd120, 1'b1}},
      '{0, REG_PANEL_LEFT, 0, 10'd25, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd69, 0, NO_SPAN},
      // corner radius beyond half the height, negative radicands
      '{1, REG_CORNER_RADIUS, 32'd63, 10'd0, 0, NO_SPAN},
      '{1, REG_PANEL_HEIGHT,  32'd20, 10'd0, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd0,  0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd10, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd19, 0, NO_SPAN},
      // maximum position and size, start x saturates
      '{1, REG_PANEL_LEFT,    32'h0fff, 10'd0, 0, NO_SPAN},
      '{1, REG_PANEL_TOP,     32'h0fff, 10'd0, 0, NO_SPAN},
      '{1, REG_PANEL_WIDTH,   32'd1023, 10'd0, 0, NO_SPAN},
      '{1, REG_PANEL_HEIGHT,  32'd1023, 10'd0, 0, NO_SPAN},
      '{1, REG_CIRCLE_RADIUS, 32'd0,    10'd0, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd0,    1, '{13'd4095, 14'd4095, 10'd960, 1'b1}},
      '{0, REG_PANEL_LEFT, 0, 10'd1022, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd1023, 1, '{13'd0, 14'd5118, 10'd0, 1'b0}},
      '{0, REG_PANEL_LEFT, 0, 10'd500,  0, NO_SPAN},
      // minimum position, zero width and zero corner radius
      '{1, REG_PANEL_LEFT,    32'h1000, 10'd0, 0, NO_SPAN},
      '{1, REG_PANEL_TOP,     32'h1000, 10'd0, 0, NO_SPAN},
      '{1, REG_PANEL_WIDTH,   32'd0,    10'd0, 0, NO_SPAN},
      '{1, REG_CORNER_RADIUS, 32'd0,    10'd0, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd0, 1, '{13'd0, 14'h3000, 10'd0, 1'b0}},
      // zero height, every row outside the panel
      '{1, REG_PANEL_WIDTH,  32'd1023, 10'd0, 0, NO_SPAN},
      '{1, REG_PANEL_HEIGHT, 32'd0,    10'd0, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd0,    1, '{13'd0, 14'h3000, 10'd0, 1'b0}},
      '{0, REG_PANEL_LEFT, 0, 10'd1023, 0, NO_SPAN},
      // largest cutting circle, centre at -2200, -3584
      '{1, REG_PANEL_HEIGHT,    32'd1023, 10'd0, 0, NO_SPAN},
      '{1, REG_CIRCLE_RADIUS,   32'd1023, 10'd0, 0, NO_SPAN},
      '{1, REG_CIRCLE_CENTER_X, 32'h1768, 10'd0, 0, NO_SPAN},
      '{1, REG_CIRCLE_CENTER_Y, 32'h1200, 10'd0, 0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd512,  0, NO_SPAN},
      '{0, REG_PANEL_LEFT, 0, 10'd1000, 0, NO_SPAN}
    };
  end

  // main sequence
  initial begin
    int          px, py, pw, ph, cr, lr, ccx, ccy;
    logic [31:0] cfg_word [8];
    reg_idx_t    r;
    bit          writing;
    cfg_shadow = '{RST_PANEL_LEFT, RST_PANEL_TOP, RST_PANEL_WIDTH, RST_PANEL_HEIGHT,
                   RST_CIRCLE_CENTER_X, RST_CIRCLE_CENTER_Y, RST_CIRCLE_RADIUS,
                   RST_CORNER_RADIUS};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    writing = 1'b0;
    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        if (!writing) begin
          drain();
          settings_used++;
        end
        writing = 1'b1;
        write_reg(plan[k].idx, plan[k].wdata);
      end else begin
        writing = 1'b0;
        send_row(plan[k].row, plan[k].lit, plan[k].want);
      end
    end

    // random settings, each followed by a burst of rows
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      if (phase == RANDOM_PHASES - 1) no_idle = 1'b1;
      px = pick_coord();
      py = pick_coord();
      case ($urandom_range(0, 7))
        0: pw = 0;
        1: pw = 1023;
        default: pw = $urandom_range(1, 1023);
      endcase
      case ($urandom_range(0, 7))
        0: ph = 0;
        1: ph = 1023;
        default: ph = $urandom_range(1, 200);
      endcase
      case ($urandom_range(0, 7))
        0: lr = 0;
        1: lr = 63;
        default: lr = $urandom_range(0, 63);
      endcase
      case ($urandom_range(0, 7))
        0: cr = 0;
        1: cr = 1023;
        default: cr = $urandom_range(1, 300);
      endcase
      // mostly place the circle so that it bites into the right edge
      if ($urandom_range(0, 4) == 0) begin
        ccx = pick_coord();
        ccy = pick_coord();
      end else begin
        ccx = clamp13(px + pw + cr - int'($urandom_range(0, 2 * cr + 20)));
        ccy = clamp13(py + int'($urandom_range(0, ph + 40)) - 20);
      end
      cfg_word[REG_PANEL_LEFT]      = {19'd0, px[12:0]};
      cfg_word[REG_PANEL_TOP]       = {19'd0, py[12:0]};
      cfg_word[REG_PANEL_WIDTH]     = {22'd0, pw[9:0]};
      cfg_word[REG_PANEL_HEIGHT]    = {22'd0, ph[9:0]};
      cfg_word[REG_CIRCLE_CENTER_X] = {19'd0, ccx[12:0]};
      cfg_word[REG_CIRCLE_CENTER_Y] = {19'd0, ccy[12:0]};
      cfg_word[REG_CIRCLE_RADIUS]   = {22'd0, cr[9:0]};
      cfg_word[REG_CORNER_RADIUS]   = {26'd0, lr[5:0]};
      r = r.first();
      repeat (8) begin
        write_reg(r, cfg_word[r]);
        r = r.next();
      end
      settings_used++;
      // one long output hold while rows keep coming
      if (phase == 2) hold_req = 1'b1;
      repeat (ROWS_PER_PHASE) send_row(pick_row(), 1'b0, NO_SPAN);
    end

    // wait out the pipeline and catch any stray result
    drain();
    repeat (2 * LATENCY) @(posedge clk);

    $display("%0d rows sent under %0d register settings, %0d spans compared",
             rows_sent, settings_used, spans_checked);
    $display("covered corners, circle cuts, empty rows, saturation and a %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rpsg_pkg.sv
rtl/core/rpsg_prep.sv
rtl/core/rpsg_cell.sv
rtl/core/rpsg_finish.sv
rtl/core/rounded_panel_span_generator.sv
rtl/core/rpsg_checker.sv
sim/tb.sv
